// ===== rtl/btlv_pkg.sv =====
// Shared types and constants for the BER-TLV stream encoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package btlv_pkg;

    // Largest number of buffer writes one input item can cause.
    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = 3;

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Fixed encoding constants.
    localparam logic [15:0] SHORT_MAX    = 16'h007F;
    localparam logic [15:0] ONE_BYTE_MAX = 16'h00FF;
    localparam logic [7:0]  LONG_FORM    = 8'h80;
    localparam logic [7:0]  WORD_LEN     = 8'h04;

    // Input item kinds.
    typedef enum logic [1:0] {
        ACT_RESTART = 2'd0,
        ACT_HEADER  = 2'd1,
        ACT_VALUE   = 2'd2,
        ACT_WORD    = 2'd3
    } action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_ROOM    = 2'd1,
        ST_UNEXPECTED = 2'd2
    } status_t;

    // One classified item, handed from front to back.
    // nbytes of zero means a single result with no buffer write.
    typedef struct packed {
        logic [15:0]                    base;
        logic [CNT_W-1:0]               nbytes;
        logic [MAX_BYTES-1:0][7:0]      bytes;
        status_t                        status;
        logic                           done;
    } job_t;

endpackage

`default_nettype wire

// ===== rtl/btlv_front.sv =====
// Front end: accepts input items, checks room and builds one job per item.
// Holds the capacity register and the write offset / open-TLV state. Uses btlv_pkg.
`default_nettype none

module btlv_front
    import btlv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    output logic             push_valid,
    input  wire logic        push_ready,
    output job_t             push_job
);

    logic [15:0] capacity_reg;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] left_reg, left_next;
    logic        open_reg, open_next;

    logic [7:0]  tag;
    logic [15:0] value_length;
    logic [7:0]  value_byte;
    logic [31:0] word_value;
    logic [17:0] need;
    logic [17:0] room;
    logic        room_ok;
    logic        word_ok;
    logic [1:0]  octets;
    logic        accept;

    assign tag          = s_tdata[7:0];
    assign value_length = s_tdata[23:8];
    assign value_byte   = s_tdata[31:24];
    assign word_value   = s_tdata[63:32];

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    // Room check against the remaining buffer capacity.
    always_comb
    begin
        if (value_length <= SHORT_MAX)
        begin
            octets = 2'd1;
        end
        else if (value_length <= ONE_BYTE_MAX)
        begin
            octets = 2'd2;
        end
        else
        begin
            octets = 2'd3;
        end
        need    = 18'd1 + {16'd0, octets} + {2'b00, value_length};
        room    = {2'b00, capacity_reg - offset_reg};
        room_ok = (offset_reg <= capacity_reg) && (need <= room);
        word_ok = (offset_reg <= capacity_reg) && (18'd6 <= room);
    end

    // Classify the item, build its job and the next state.
    always_comb
    begin
        offset_next   = offset_reg;
        left_next     = left_reg;
        open_next     = open_reg;
        push_job      = '0;
        push_job.base = offset_reg;
        case (action_t'(s_tuser))
            ACT_RESTART:
            begin
                offset_next   = 16'd0;
                left_next     = 16'd0;
                open_next     = 1'b0;
                push_job.base = 16'd0;
            end
            ACT_HEADER:
            begin
                left_next = 16'd0;
                open_next = 1'b0;
                if (!room_ok)
                begin
                    push_job.status = ST_NO_ROOM;
                end
                else
                begin
                    push_job.bytes[0] = tag;
                    case (octets)
                        2'd1:
                        begin
                            push_job.bytes[1] = value_length[7:0];
                        end
                        2'd2:
                        begin
                            push_job.bytes[1] = LONG_FORM | 8'd1;
                            push_job.bytes[2] = value_length[7:0];
                        end
                        default:
                        begin
                            push_job.bytes[1] = LONG_FORM | 8'd2;
                            push_job.bytes[2] = value_length[15:8];
                            push_job.bytes[3] = value_length[7:0];
                        end
                    endcase
                    push_job.nbytes = CNT_W'(octets) + CNT_W'(1);
                    push_job.done   = (value_length == 16'd0);
                    offset_next     = offset_reg + 16'(octets) + 16'd1;
                    if (value_length != 16'd0)
                    begin
                        open_next = 1'b1;
                        left_next = value_length;
                    end
                end
            end
            ACT_VALUE:
            begin
                if (!open_reg || left_reg == 16'd0)
                begin
                    open_next       = 1'b0;
                    push_job.status = ST_UNEXPECTED;
                end
                else
                begin
                    left_next         = left_reg - 16'd1;
                    open_next         = (left_reg != 16'd1);
                    push_job.bytes[0] = value_byte;
                    push_job.nbytes   = CNT_W'(1);
                    push_job.done     = (left_reg == 16'd1);
                    offset_next       = offset_reg + 16'd1;
                end
            end
            default:
            begin
                // Whole TLV with a four-byte big-endian value.
                left_next = 16'd0;
                open_next = 1'b0;
                if (!word_ok)
                begin
                    push_job.status = ST_NO_ROOM;
                end
                else
                begin
                    push_job.bytes[0] = tag;
                    push_job.bytes[1] = WORD_LEN;
                    push_job.bytes[2] = word_value[31:24];
                    push_job.bytes[3] = word_value[23:16];
                    push_job.bytes[4] = word_value[15:8];
                    push_job.bytes[5] = word_value[7:0];
                    push_job.nbytes   = CNT_W'(MAX_BYTES);
                    push_job.done     = 1'b1;
                    offset_next       = offset_reg + 16'd6;
                end
            end
        endcase
    end

    // Capacity register and encoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= 16'hFFFF;
            offset_reg   <= 16'd0;
            left_reg     <= 16'd0;
            open_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                offset_reg <= offset_next;
                left_reg   <= left_next;
                open_reg   <= open_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/btlv_queue.sv =====
// Short job queue between front and back so each side can stall on its own.
// Register-based FIFO of btlv_pkg::job_t entries.
`default_nettype none

module btlv_queue
    import btlv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  job_t      push_job,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    job_t               entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_QW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/btlv_back.sv =====
// Back end: walks one job a byte at a time and drives the registered output.
// Uses btlv_pkg for the job type and status codes.
`default_nettype none

module btlv_back
    import btlv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pop_valid,
    output logic             pop_ready,
    input  job_t             pop_job,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             valid_reg;
    logic [7:0]       byte_reg, byte_next;
    logic [15:0]      addr_reg, addr_next;
    logic             bvalid_reg, bvalid_next;
    status_t          status_reg, status_next;
    logic             done_reg, done_next;
    logic [15:0]      end_reg, end_next;
    logic             last_reg, last_next;
    logic             load;
    logic             job_last;

    assign load      = pop_valid && (!valid_reg || m_tready);
    assign job_last  = (pop_job.nbytes == '0) || (idx_reg == pop_job.nbytes - CNT_W'(1));
    assign pop_ready = load && job_last;

    // Result for the current byte of the head job.
    always_comb
    begin
        idx_next    = job_last ? '0 : idx_reg + CNT_W'(1);
        last_next   = job_last;
        status_next = pop_job.status;
        if (pop_job.nbytes == '0)
        begin
            byte_next   = 8'd0;
            addr_next   = 16'd0;
            bvalid_next = 1'b0;
            done_next   = 1'b0;
            end_next    = 16'd0;
        end
        else
        begin
            byte_next   = pop_job.bytes[idx_reg];
            addr_next   = pop_job.base + 16'(idx_reg);
            bvalid_next = 1'b1;
            done_next   = job_last && pop_job.done;
            end_next    = done_next ? pop_job.base + 16'(pop_job.nbytes) : 16'd0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg   <= idx_next;
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_next;
            addr_reg   <= addr_next;
            bvalid_reg <= bvalid_next;
            status_reg <= status_next;
            done_reg   <= done_next;
            end_reg    <= end_next;
            last_reg   <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, end_reg, done_reg, addr_reg, byte_reg};
    assign m_tuser  = {status_reg, bvalid_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/ber_tlv_stream_encoder_unit.sv =====
// BER-TLV stream encoder, top level. An accepted input item is written to the
// job queue, and its first result is then loaded into the output register.
// The back end writes one byte result per cycle unless m_tready stalls it;
// an item causes one result for restart, value bytes and rejects, two to
// four for headers and six for word TLVs. rst_n clears state asynchronously:
// offset 0, no TLV open, capacity 65535, queue and output empty.
`default_nettype none

module ber_tlv_stream_encoder_unit
    import btlv_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,    // capacity
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,        // tag, value_length, value_byte, word_value
    input  wire logic [1:0]  s_tuser,        // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,        // out_byte, write_addr, tlv_done, end_offset, pad
    output logic [2:0]       m_tuser,        // byte_valid, status
    output logic             m_tlast
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    // Accept and classify.
    btlv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // Decoupling queue.
    btlv_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_job  (push_job),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job)
    );

    // Byte emitter.
    btlv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_job  (pop_job),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
